// File: design/dbas_pkg.sv
// dbas_pkg: shared types and constants for the decimal add/subtract block
// used by dbas_ctrl, dbas_dp and decimal_bignum_add_sub_top; no dependencies
package dbas_pkg;

	localparam int MAX_DIGITS_DEF = 32;
	localparam logic [4:0] DEC_BASE = 5'd10;
	localparam logic [3:0] DIGIT_MAX = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP_RD,
		ST_CMP_USE,
		ST_ARI_RD,
		ST_ARI_USE,
		ST_FIX,
		ST_EMIT
	} dbas_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic init;
		logic rd;
		logic rd_rev;
		logic cmp_use;
		logic ari_use;
		logic fix;
		logic emit;
		logic err;
	} dbas_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic run_req;
		logic len_zero;
		logic op_sub;
		logic last_step;
		logic emit_last;
	} dbas_sts_t;

endpackage

// File: design/dbas_ctrl.sv
// dbas_ctrl: sequencer for loading, compare, digit arithmetic and emission
// depends on dbas_pkg
module dbas_ctrl import dbas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dbas_sts_t  sts,
	output dbas_cmd_t  cmd,
	output logic       busy
);

	dbas_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (sts.run_req) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (sts.len_zero) begin
					cmd.err = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.init = 1'b1;
					state_d = sts.op_sub ? ST_CMP_RD : ST_ARI_RD;
				end
			end
			ST_CMP_RD: begin
				cmd.rd = 1'b1;
				cmd.rd_rev = 1'b1;
				state_d = ST_CMP_USE;
			end
			ST_CMP_USE: begin
				cmd.cmp_use = 1'b1;
				state_d = sts.last_step ? ST_ARI_RD : ST_CMP_RD;
			end
			ST_ARI_RD: begin
				cmd.rd = 1'b1;
				state_d = ST_ARI_USE;
			end
			ST_ARI_USE: begin
				cmd.ari_use = 1'b1;
				state_d = sts.last_step ? ST_FIX : ST_ARI_RD;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/dbas_dp.sv
// dbas_dp: operand stores, digit compare/add/subtract unit, result store
// depends on dbas_pkg; driven by dbas_ctrl commands
module dbas_dp import dbas_pkg::*; #(
	parameter int MaxDigits = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dbas_cmd_t  cmd,
	output dbas_sts_t  sts,
	input  logic       operand_sel,
	input  logic [3:0] digit_value,
	input  logic       last_digit,
	input  logic       operation,
	output logic [3:0] result_digit,
	output logic       negative,
	output logic       last_of_run,
	output logic       carry_lost,
	output logic       format_error,
	output logic       strobe
);

	localparam int LW  = $clog2(MaxDigits + 1);
	localparam int AW  = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
	localparam int RAW = $clog2(MaxDigits + 1);
	localparam int RLW = $clog2(MaxDigits + 2);

	logic [3:0] mem_a [MaxDigits];
	logic [3:0] mem_b [MaxDigits];
	logic [3:0] mem_r [MaxDigits + 1];

	logic [LW-1:0]  len_a_q, len_b_q, p_q, nz_q;
	logic [RLW-1:0] rlen_q, k_q;
	logic [3:0]     rd_a_q, rd_b_q;
	logic           va_q, vb_q;
	logic           op_q, neg_q, dec_q, carry_q, lost_q;

	logic [LW-1:0]  maxlen, last_pos, pos, addr_a_full, addr_b_full;
	logic [RLW-1:0] emit_idx;
	logic [RAW-1:0] wr_addr;
	logic           digit_ok, room_a, room_b, wr_en, room_carry;
	logic [3:0]     xa, yb, big, sml, d_new, wr_data;
	logic [4:0]     zsum, tsub;
	logic           sum_ge, lt, c_new;

	assign digit_ok = digit_value <= DIGIT_MAX;
	assign room_a = len_a_q < LW'(MaxDigits);
	assign room_b = len_b_q < LW'(MaxDigits);

	assign maxlen = (len_a_q > len_b_q) ? len_a_q : len_b_q;
	assign last_pos = maxlen - LW'(1);
	// compare walks from the most significant weight down
	assign pos = cmd.rd_rev ? (last_pos - p_q) : p_q;
	assign addr_a_full = len_a_q - LW'(1) - pos;
	assign addr_b_full = len_b_q - LW'(1) - pos;
	assign room_carry = maxlen < LW'(MaxDigits);

	assign xa = va_q ? rd_a_q : 4'd0;
	assign yb = vb_q ? rd_b_q : 4'd0;
	assign big = neg_q ? yb : xa;
	assign sml = neg_q ? xa : yb;

	always_comb begin
		zsum = {1'b0, big} + {1'b0, sml} + {4'd0, carry_q};
		sum_ge = zsum >= DEC_BASE;
		tsub = {1'b0, sml} + {4'd0, carry_q};
		lt = {1'b0, big} < tsub;
		if (op_q) begin
			d_new = lt ? 4'({1'b0, big} + DEC_BASE - tsub) : 4'({1'b0, big} - tsub);
			c_new = lt;
		end else begin
			d_new = sum_ge ? 4'(zsum - DEC_BASE) : zsum[3:0];
			c_new = sum_ge;
		end
	end

	assign emit_idx = rlen_q - RLW'(1) - k_q;
	assign wr_en = cmd.ari_use || (cmd.fix && !op_q && carry_q && room_carry);
	assign wr_addr = cmd.ari_use ? p_q[RAW-1:0] : maxlen[RAW-1:0];
	assign wr_data = cmd.ari_use ? d_new : 4'd1;

	assign sts.run_req = operand_sel && last_digit;
	assign sts.len_zero = (len_a_q == '0) || (len_b_q == '0);
	assign sts.op_sub = op_q;
	assign sts.last_step = p_q == last_pos;
	assign sts.emit_last = k_q == (rlen_q - RLW'(1));

	// operand stores
	always_ff @(posedge clk) begin
		if (cmd.load && digit_ok && !operand_sel && room_a) begin
			mem_a[len_a_q[AW-1:0]] <= digit_value;
		end
		if (cmd.load && digit_ok && operand_sel && room_b) begin
			mem_b[len_b_q[AW-1:0]] <= digit_value;
		end
		if (cmd.rd) begin
			rd_a_q <= mem_a[addr_a_full[AW-1:0]];
			rd_b_q <= mem_b[addr_b_full[AW-1:0]];
		end
	end

	// result store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_r[wr_addr] <= wr_data;
		end
		if (cmd.emit) begin
			result_digit <= mem_r[emit_idx[RAW-1:0]];
		end else if (cmd.err) begin
			result_digit <= 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			op_q <= 1'b0;
			va_q <= 1'b0;
			vb_q <= 1'b0;
			p_q <= '0;
			nz_q <= '0;
			rlen_q <= '0;
			k_q <= '0;
			neg_q <= 1'b0;
			dec_q <= 1'b0;
			carry_q <= 1'b0;
			lost_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (digit_ok && !operand_sel && room_a) begin
					len_a_q <= len_a_q + LW'(1);
				end
				if (digit_ok && operand_sel && room_b) begin
					len_b_q <= len_b_q + LW'(1);
				end
				if (operand_sel && last_digit) begin
					op_q <= operation;
				end
			end
			if (cmd.err || cmd.fix) begin
				len_a_q <= '0;
				len_b_q <= '0;
			end
			if (cmd.init) begin
				p_q <= '0;
				nz_q <= '0;
				neg_q <= 1'b0;
				dec_q <= 1'b0;
				carry_q <= 1'b0;
				lost_q <= 1'b0;
			end
			if (cmd.rd) begin
				va_q <= pos < len_a_q;
				vb_q <= pos < len_b_q;
			end
			if (cmd.cmp_use) begin
				// first differing digit from the top decides the sign
				if (!dec_q && xa != yb) begin
					dec_q <= 1'b1;
					neg_q <= xa < yb;
				end
				p_q <= sts.last_step ? '0 : p_q + LW'(1);
			end
			if (cmd.ari_use) begin
				carry_q <= c_new;
				if (d_new != 4'd0) begin
					nz_q <= p_q + LW'(1);
				end
				p_q <= p_q + LW'(1);
			end
			if (cmd.fix) begin
				k_q <= '0;
				if (op_q) begin
					rlen_q <= (nz_q == '0) ? RLW'(1) : RLW'(nz_q);
				end else if (carry_q && room_carry) begin
					rlen_q <= RLW'(maxlen) + RLW'(1);
				end else begin
					rlen_q <= RLW'(maxlen);
					lost_q <= carry_q;
				end
			end
			if (cmd.emit) begin
				k_q <= k_q + RLW'(1);
			end
		end
	end

	// result flags line up with the registered digit read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			last_of_run <= 1'b0;
			negative <= 1'b0;
			carry_lost <= 1'b0;
			format_error <= 1'b0;
		end else begin
			strobe <= cmd.emit || cmd.err;
			last_of_run <= cmd.err || (cmd.emit && sts.emit_last);
			negative <= cmd.emit && neg_q;
			carry_lost <= cmd.emit && lost_q;
			format_error <= cmd.err;
		end
	end

endmodule

// File: design/decimal_bignum_add_sub_top.sv
// decimal_bignum_add_sub_top: multi-digit decimal adder/subtractor
// depends on dbas_pkg, dbas_ctrl, dbas_dp
//
// usage: a word (one operand digit) is taken at a clock edge with start high
// and busy low. operand_sel picks A or B, digits arrive most significant first.
// digits above nine are ignored; digits past MaxDigits per operand are dropped.
// the word with operand_sel=1 and last_digit=1 starts the run, operation
// (0 add, 1 subtract) is taken from that word. busy is high during the run.
// a run passes a check state, then a compare pass over the digits of the
// longer operand (subtract only) and an arithmetic pass, each digit read
// in a RD state and used in a USE state, set by the registered read of the
// operand stores, then a fix-up state and the registered result store
// read, then one result word per cycle.
// an empty operand gives one format_error word, registered from the check
// state that follows the closing word.
// results appear for one cycle each, marked by strobe, most significant
// first; last_of_run flags the final one. the receiver cannot stall.
// reset empties both operands and drops any run in progress; the digit
// stores themselves are not cleared, only their lengths.
module decimal_bignum_add_sub_top import dbas_pkg::*; #(
	parameter int MaxDigits = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       operand_sel,
	input  logic [3:0] digit_value,
	input  logic       last_digit,
	input  logic       operation,
	output logic       strobe,
	output logic [3:0] result_digit,
	output logic       negative,
	output logic       last_of_run,
	output logic       carry_lost,
	output logic       format_error
);

	dbas_cmd_t cmd;
	dbas_sts_t sts;

	dbas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dbas_dp #(
		.MaxDigits (MaxDigits)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operand_sel  (operand_sel),
		.digit_value  (digit_value),
		.last_digit   (last_digit),
		.operation    (operation),
		.result_digit (result_digit),
		.negative     (negative),
		.last_of_run  (last_of_run),
		.carry_lost   (carry_lost),
		.format_error (format_error),
		.strobe       (strobe)
	);

endmodule

// File: design/dbas_chk.sv
// dbas_chk: port-level checks for decimal_bignum_add_sub_top, bound below
// depends on nothing but the top level's ports
module dbas_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       operand_sel,
	input logic       last_digit,
	input logic       strobe,
	input logic [3:0] result_digit,
	input logic       negative,
	input logic       last_of_run,
	input logic       carry_lost,
	input logic       format_error
);

	// a run always starts after the word that closes operand B
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operand_sel && last_digit |=> busy)
		else $error("run did not start");

	// result words of one run come back to back
	a_emit_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_run |=> strobe)
		else $error("gap inside a result run");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && format_error |-> last_of_run && result_digit == 4'd0
			&& !negative && !carry_lost)
		else $error("bad format error word");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !format_error |-> result_digit <= 4'd9)
		else $error("result digit out of range");

	a_sign_vs_carry: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(negative && carry_lost))
		else $error("negative and carry_lost together");

endmodule

bind decimal_bignum_add_sub_top dbas_chk u_dbas_chk (.*);

// File: tb/dbas_result_checker.sv
`timescale 1ns / 100ps
// dbas_result_checker: watches the word and result channels of the decimal add/subtract block,
// predicts the result digits of every run and compares them; depends on dbas_pkg
module dbas_result_checker import dbas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       operand_sel,
	input  logic [3:0] digit_value,
	input  logic       last_digit,
	input  logic       operation,
	input  logic       strobe,
	input  logic [3:0] result_digit,
	input  logic       negative,
	input  logic       last_of_run,
	input  logic       carry_lost,
	input  logic       format_error,
	output int         fail_count,
	output int         pending
);

	localparam int NDIG = MAX_DIGITS_DEF;

	typedef struct packed {
		logic [3:0] digit;
		logic       neg;
		logic       last;
		logic       lost;
		logic       ferr;
	} res_word_t;

	res_word_t  expected_digits[$];
	res_word_t  head;
	logic [3:0] store_a [NDIG];
	logic [3:0] store_b [NDIG];
	int         len_a;
	int         len_b;
	int         mismatches;

	// digit at weight p, zero above the operand length
	function automatic int a_at(input int p);
		return (p < len_a) ? int'(store_a[len_a - 1 - p]) : 0;
	endfunction

	function automatic int b_at(input int p);
		return (p < len_b) ? int'(store_b[len_b - 1 - p]) : 0;
	endfunction

	task automatic add_sub_operands(input logic subtract);
		logic [3:0] sum_digits [NDIG + 1];
		int         wide;
		int         rlen;
		int         cmp;
		int         carry;
		int         x;
		int         y;
		int         z;
		logic       neg;
		logic       lost;
		res_word_t  w;
		neg = 1'b0;
		lost = 1'b0;
		if (len_a == 0 || len_b == 0) begin
			w = '{digit: 4'd0, neg: 1'b0, last: 1'b1, lost: 1'b0, ferr: 1'b1};
			expected_digits.push_back(w);
			len_a = 0;
			len_b = 0;
			return;
		end
		wide = (len_a > len_b) ? len_a : len_b;
		carry = 0;
		if (!subtract) begin
			for (int p = 0; p < wide; p++) begin
				z = a_at(p) + b_at(p) + carry;
				sum_digits[p] = 4'(z % 10);
				carry = z / 10;
			end
			rlen = wide;
			if (carry != 0) begin
				if (wide < NDIG) begin
					sum_digits[rlen] = 4'(carry);
					rlen++;
				end else begin
					lost = 1'b1;
				end
			end
		end else begin
			// compare by value, top weight down; leading zeros read as zero
			cmp = 0;
			for (int p = wide - 1; p >= 0 && cmp == 0; p--) begin
				if (a_at(p) != b_at(p))
					cmp = (a_at(p) > b_at(p)) ? 1 : -1;
			end
			neg = (cmp < 0);
			for (int p = 0; p < wide; p++) begin
				x = neg ? b_at(p) : a_at(p);
				y = (neg ? a_at(p) : b_at(p)) + carry;
				if (x < y) begin
					sum_digits[p] = 4'(x + 10 - y);
					carry = 1;
				end else begin
					sum_digits[p] = 4'(x - y);
					carry = 0;
				end
			end
			rlen = wide;
			while (rlen > 1 && sum_digits[rlen - 1] == 4'd0)
				rlen--;
		end
		for (int k = 0; k < rlen; k++) begin
			w = '{digit: sum_digits[rlen - 1 - k], neg: neg, last: (k == rlen - 1),
				lost: lost, ferr: 1'b0};
			expected_digits.push_back(w);
		end
		len_a = 0;
		len_b = 0;
	endtask

	task automatic take_word();
		if (digit_value <= DIGIT_MAX) begin
			if (!operand_sel) begin
				if (len_a < NDIG) begin
					store_a[len_a] = digit_value;
					len_a++;
				end
			end else if (len_b < NDIG) begin
				store_b[len_b] = digit_value;
				len_b++;
			end
		end
		if (operand_sel && last_digit)
			add_sub_operands(operation);
	endtask

	task automatic check_field(input string name, input logic [3:0] exp_v,
		input logic [3:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a = 0;
			len_b = 0;
			mismatches = 0;
			expected_digits.delete();
		end else begin
			// a result and a new word cannot belong to the same run
			if (strobe === 1'b1) begin
				if (expected_digits.size() == 0) begin
					$error("result word with none expected: digit %0d", result_digit);
					mismatches++;
				end else begin
					head = expected_digits.pop_front();
					check_field("result_digit", head.digit, result_digit);
					check_field("negative", {3'd0, head.neg}, {3'd0, negative});
					check_field("last_of_run", {3'd0, head.last}, {3'd0, last_of_run});
					check_field("carry_lost", {3'd0, head.lost}, {3'd0, carry_lost});
					check_field("format_error", {3'd0, head.ferr}, {3'd0, format_error});
				end
			end
			if (start && !busy)
				take_word();
		end
		pending <= expected_digits.size();
		fail_count <= mismatches;
	end

endmodule

// File: tb/decimal_bignum_add_sub_top_tb.sv
`timescale 1ns / 100ps
// decimal_bignum_add_sub_top_tb: stimulus and verdict for the decimal add/subtract block
// depends on dbas_pkg, decimal_bignum_add_sub_top and dbas_result_checker
module decimal_bignum_add_sub_top_tb import dbas_pkg::*; ();

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;
	localparam logic SEL_A = 1'b0;
	localparam logic SEL_B = 1'b1;
	localparam int WORD_TARGET = 310;
	localparam int QUIET_FROM = 255;
	localparam int RUN_TAIL = 200;

	// digit patterns for operand content
	localparam int PAT_UNIFORM = 0;
	localparam int PAT_NINES = 1;
	localparam int PAT_ZEROS = 2;
	localparam int PAT_MIRROR = 3;
	localparam int PAT_ALL_NINES = 4;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       operand_sel;
	logic [3:0] digit_value;
	logic       last_digit;
	logic       operation;
	logic       strobe;
	logic [3:0] result_digit;
	logic       negative;
	logic       last_of_run;
	logic       carry_lost;
	logic       format_error;
	int         fail_count;
	int         pending;
	int         words_done;
	bit         gaps_on;

	decimal_bignum_add_sub_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operand_sel  (operand_sel),
		.digit_value  (digit_value),
		.last_digit   (last_digit),
		.operation    (operation),
		.strobe       (strobe),
		.result_digit (result_digit),
		.negative     (negative),
		.last_of_run  (last_of_run),
		.carry_lost   (carry_lost),
		.format_error (format_error)
	);

	dbas_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operand_sel  (operand_sel),
		.digit_value  (digit_value),
		.last_digit   (last_digit),
		.operation    (operation),
		.strobe       (strobe),
		.result_digit (result_digit),
		.negative     (negative),
		.last_of_run  (last_of_run),
		.carry_lost   (carry_lost),
		.format_error (format_error),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic send_word(input logic sel, input logic [3:0] d, input logic lst,
		input logic op);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start <= 1'b1;
		operand_sel <= sel;
		digit_value <= d;
		last_digit <= lst;
		operation <= op;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (d <= DIGIT_MAX)
			words_done++;
	endtask

	// hold the sender off until every expected result word has come
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	function automatic logic [3:0] pick_digit(input int pat);
		case (pat)
			PAT_NINES: begin
				return ($urandom_range(0, 4) != 0) ? DIGIT_MAX : 4'($urandom_range(0, 9));
			end
			PAT_ZEROS: begin
				return ($urandom_range(0, 2) != 0) ? 4'd0 : 4'($urandom_range(0, 9));
			end
			PAT_ALL_NINES: begin
				return DIGIT_MAX;
			end
			default: begin
				return 4'($urandom_range(0, 9));
			end
		endcase
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 6);
		else if (r < 18)
			return $urandom_range(7, 16);
		return $urandom_range(17, 36);
	endfunction

	// loads A then B; an empty B is closed by an ignored digit carrying the last mark
	task automatic send_operands(input int la, input int lb, input int pat, input logic op);
		logic [3:0] a_digs [$];
		logic [3:0] d;
		for (int i = 0; i < la; i++) begin
			d = pick_digit(pat);
			a_digs.push_back(d);
			if ($urandom_range(0, 15) == 0)
				send_word(SEL_A, 4'($urandom_range(10, 15)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			send_word(SEL_A, d, (i == la - 1) || ($urandom_range(0, 7) == 0),
				1'($urandom_range(0, 1)));
		end
		for (int i = 0; i < lb; i++) begin
			d = (pat == PAT_MIRROR && i < la) ? a_digs[i] : pick_digit(pat);
			if ($urandom_range(0, 15) == 0)
				send_word(SEL_B, 4'($urandom_range(10, 15)), 1'b0, 1'($urandom_range(0, 1)));
			if (i == lb - 1)
				send_word(SEL_B, d, 1'b1, op);
			else
				send_word(SEL_B, d, 1'b0, 1'($urandom_range(0, 1)));
		end
		if (lb == 0)
			send_word(SEL_B, 4'($urandom_range(10, 15)), 1'b1, op);
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int la;
		int lb;
		int pat;
		int kind;
		arst_n = 1'b0;
		start = 1'b0;
		operand_sel = 1'b0;
		digit_value = 4'd0;
		last_digit = 1'b0;
		operation = 1'b0;
		words_done = 0;
		gaps_on = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 9 + 9 grows by one digit
		send_word(SEL_A, 4'd9, 1'b1, OP_SUB);
		send_word(SEL_B, 4'd9, 1'b1, OP_ADD);
		// 5 - 7 is negative
		send_word(SEL_A, 4'd5, 1'b1, OP_ADD);
		send_word(SEL_B, 4'd7, 1'b1, OP_SUB);
		// equal operands give a single zero
		send_word(SEL_A, 4'd4, 1'b0, OP_ADD);
		send_word(SEL_A, 4'd2, 1'b1, OP_ADD);
		send_word(SEL_B, 4'd4, 1'b0, OP_ADD);
		send_word(SEL_B, 4'd2, 1'b1, OP_SUB);
		// empty A
		send_word(SEL_B, 4'd3, 1'b1, OP_SUB);
		// leading zeros compare by value: 007 - 8
		send_word(SEL_A, 4'd0, 1'b0, OP_ADD);
		send_word(SEL_A, 4'd0, 1'b0, OP_ADD);
		send_word(SEL_A, 4'd7, 1'b1, OP_ADD);
		send_word(SEL_B, 4'd8, 1'b1, OP_SUB);
		// ignored digits, last mark on A that does not end A
		send_word(SEL_A, 4'd12, 1'b1, OP_SUB);
		send_word(SEL_A, 4'd3, 1'b1, OP_SUB);
		send_word(SEL_A, 4'd1, 1'b0, OP_SUB);
		send_word(SEL_B, 4'd4, 1'b0, OP_SUB);
		send_word(SEL_B, 4'd11, 1'b1, OP_ADD);
		// empty B
		send_word(SEL_A, 4'd6, 1'b1, OP_ADD);
		send_word(SEL_B, 4'd15, 1'b1, OP_ADD);
		drain_results();

		words_done = 0;
		gaps_on = 1'b1;
		// full stores: dropped digits and a lost carry, then a long subtract
		send_operands(34, 32, PAT_ALL_NINES, OP_ADD);
		send_operands(32, 33, PAT_UNIFORM, OP_SUB);
		drain_results();

		while (words_done < WORD_TARGET) begin
			gaps_on = (words_done < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				repeat ($urandom_range(1, 4))
					send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (kind == 1) begin
				if ($urandom_range(0, 1) == 0)
					send_operands(0, pick_len(), PAT_UNIFORM, 1'($urandom_range(0, 1)));
				else
					send_operands(pick_len(), 0, PAT_UNIFORM, 1'($urandom_range(0, 1)));
			end else begin
				pat = $urandom_range(PAT_UNIFORM, PAT_MIRROR);
				la = pick_len();
				lb = (pat == PAT_MIRROR && $urandom_range(0, 2) != 0) ? la : pick_len();
				send_operands(la, lb, pat, 1'($urandom_range(0, 1)));
			end
		end

		gaps_on = 1'b0;
		drain_results();
		repeat (RUN_TAIL) @(posedge clk);
		if (pending != 0)
			$error("%0d result words never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
